FILE: hw/rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// Triangle tangent space: shared definitions
// Word types, controller states, datapath command codes and operand tables.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

    localparam int unsigned SQRT_STEPS = 32;
    localparam int unsigned DIV_STEPS  = 15;
    localparam int unsigned CNT_W      = $clog2(SQRT_STEPS);

    localparam logic [15:0] THR_RESET = 16'd1;

    localparam logic [2:0] IDX_X = 3'd0;
    localparam logic [2:0] IDX_Y = 3'd1;
    localparam logic [2:0] IDX_Z = 3'd2;
    localparam logic [2:0] IDX_S = 3'd3;
    localparam logic [2:0] IDX_T = 3'd4;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tex_s;
        logic signed [31:0] tex_t;
    } t_vtx;

    typedef struct packed {
        logic signed [15:0] tangent_x;
        logic signed [15:0] tangent_y;
        logic signed [15:0] tangent_z;
        logic signed [15:0] binormal_x;
        logic signed [15:0] binormal_y;
        logic signed [15:0] binormal_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               degenerate;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE, S_CP, S_NLOAD, S_NSHIFT, S_SQ, S_SQRT_INIT, S_SQRT,
        S_DIV_INIT, S_DIV, S_NSTORE, S_BO, S_DOT, S_FLIP, S_OUT
    } t_state;

    typedef enum logic [2:0] {J_DET, J_TAN, J_BIN, J_TB, J_NT, J_FACE} t_job;

    typedef enum logic [2:0] {
        G_ZERO, G_E0, G_E1, G_TAN, G_BIN, G_NRM, G_FACE, G_MAG
    } t_grp;

    typedef struct packed {
        t_grp       grp;
        logic [2:0] idx;
    } t_opnd;

    typedef struct packed {
        t_opnd a;
        t_opnd b;
    } t_mul_sel;

    typedef enum logic [1:0] {ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SUB} t_acc_op;

    typedef enum logic [3:0] {
        OP_NONE, OP_CAP_FIRST, OP_CAP_SECOND, OP_EDGES, OP_NORM_LOAD,
        OP_NORM_SHIFT, OP_SQRT_INIT, OP_SQRT_STEP, OP_DIV_INIT, OP_DIV_STEP,
        OP_NORM_STORE, OP_BO, OP_FLIP, OP_OUT
    } t_dp_op;

    typedef enum logic [1:0] {VEC_TAN, VEC_BIN, VEC_NRM, VEC_FACE} t_vec;

    typedef struct packed {
        t_dp_op     op;
        t_acc_op    acc_op;
        t_mul_sel   mul;
        logic       st_v;
        logic       st_det;
        logic [1:0] comp;
        logic       mask;
        logic       flip;
        t_vec       dest;
    } t_cmd;

    typedef struct packed {
        logic shift_needed;
    } t_status;

    function automatic logic [2:0] nxt1(logic [1:0] c);
        case (c)
            2'd0:    nxt1 = IDX_Y;
            2'd1:    nxt1 = IDX_Z;
            default: nxt1 = IDX_X;
        endcase
    endfunction

    function automatic logic [2:0] nxt2(logic [1:0] c);
        case (c)
            2'd0:    nxt2 = IDX_Z;
            2'd1:    nxt2 = IDX_X;
            default: nxt2 = IDX_Y;
        endcase
    endfunction

    function automatic t_opnd opnd(t_grp g, logic [2:0] i);
        opnd.grp = g;
        opnd.idx = i;
    endfunction

    function automatic t_mul_sel cross_sel(t_grp ga, t_grp gb, logic [1:0] c, logic term);
        if (!term) begin
            cross_sel.a = opnd(ga, nxt1(c));
            cross_sel.b = opnd(gb, nxt2(c));
        end else begin
            cross_sel.a = opnd(ga, nxt2(c));
            cross_sel.b = opnd(gb, nxt1(c));
        end
    endfunction

    function automatic t_mul_sel job_sel(t_job j, logic [1:0] c, logic term);
        logic [2:0] c3;
        c3 = {1'b0, c};
        job_sel = '0;
        case (j)
            J_DET: begin
                job_sel.a = term ? opnd(G_E0, IDX_T) : opnd(G_E0, IDX_S);
                job_sel.b = term ? opnd(G_E1, IDX_S) : opnd(G_E1, IDX_T);
            end
            J_TAN: begin
                job_sel.a = term ? opnd(G_E0, c3) : opnd(G_E0, IDX_T);
                job_sel.b = term ? opnd(G_E1, IDX_T) : opnd(G_E1, c3);
            end
            J_BIN: begin
                job_sel.a = term ? opnd(G_E0, IDX_S) : opnd(G_E0, c3);
                job_sel.b = term ? opnd(G_E1, c3) : opnd(G_E1, IDX_S);
            end
            J_TB:    job_sel = cross_sel(G_TAN, G_BIN, c, term);
            J_NT:    job_sel = cross_sel(G_NRM, G_TAN, c, term);
            J_FACE:  job_sel = cross_sel(G_E1, G_E0, c, term);
            default: job_sel = '0;
        endcase
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/triangle_tangent_space.sv
// ----------------------------------------------------------------------------
// Triangle tangent space
// Per-triangle unit tangent, orthogonalised binormal and face-aligned normal.
// ----------------------------------------------------------------------------
// The first and second vertex of a triangle are each stored as a corner.
// The third starts the work on the triangle, paced by the shared
// multiplier for the cross products and by four normalisations, each a
// one-bit-per-cycle shift, a 32-step square root and a 15-step division,
// plus any wait for the previous output word to be taken.
// Reset is synchronous and active low: the corner count is cleared, the
// threshold reads 1 and the output word is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_tangent_space import tts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_vtx        i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_res        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    tts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    tts_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_vtx      (i_in_data),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_res      (o_out_data)
    );

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_OUT) |-> (!o_out_valid || !i_out_stall))
        else $error("Output word loaded over one still waiting.");

    a_out_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_OUT) |=> o_out_valid)
        else $error("Loaded output word not shown as valid.");

    a_busy_after_third: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_EDGES) |=> o_in_stall)
        else $error("Input taken while a triangle is being worked on.");

    a_out_not_with_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_OUT) |-> o_in_stall)
        else $error("Output loaded while the input side is open.");

endmodule

`default_nettype wire

FILE: hw/rtl/tts_ctrl.sv
// ----------------------------------------------------------------------------
// Triangle tangent space: controller
// Counts corners, sequences the cross products, normalisations and output.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_ctrl import tts_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state           r_state, n_state;
    t_job             r_job, n_job;
    logic [1:0]       r_comp, n_comp;
    logic [1:0]       r_ph, n_ph;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_corners, n_corners;
    logic             r_out_valid, n_out_valid;
    logic             w_accept;
    t_cmd             w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_job       <= J_DET;
            r_comp      <= 2'd0;
            r_ph        <= 2'd0;
            r_cnt       <= '0;
            r_corners   <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_job       <= n_job;
            r_comp      <= n_comp;
            r_ph        <= n_ph;
            r_cnt       <= n_cnt;
            r_corners   <= n_corners;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_comp      = r_comp;
        n_ph        = r_ph;
        n_cnt       = r_cnt;
        n_corners   = r_corners;
        n_out_valid = r_out_valid;
        w_cmd       = '0;
        w_cmd.op    = OP_NONE;
        w_accept    = i_in_valid && (r_state == S_IDLE);

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (r_corners)
                        2'd1: begin
                            w_cmd.op  = OP_CAP_SECOND;
                            n_corners = 2'd2;
                        end
                        2'd2: begin
                            w_cmd.op  = OP_EDGES;
                            n_corners = 2'd0;
                            n_job     = J_DET;
                            n_comp    = 2'd0;
                            n_ph      = 2'd0;
                            n_state   = S_CP;
                        end
                        default: begin
                            w_cmd.op  = OP_CAP_FIRST;
                            n_corners = 2'd1;
                        end
                    endcase
                end
            end
            S_CP: begin
                n_ph = 2'(r_ph + 2'd1);
                case (r_ph)
                    2'd0: w_cmd.mul = job_sel(r_job, r_comp, 1'b0);
                    2'd1: begin
                        w_cmd.mul    = job_sel(r_job, r_comp, 1'b1);
                        w_cmd.acc_op = ACC_LOAD;
                    end
                    2'd2: w_cmd.acc_op = ACC_SUB;
                    default: begin
                        w_cmd.st_det = (r_job == J_DET);
                        w_cmd.st_v   = (r_job != J_DET);
                        w_cmd.comp   = r_comp;
                        w_cmd.mask   = r_job inside {J_TAN, J_BIN};
                        n_ph         = 2'd0;
                        if ((r_job != J_DET) && (r_comp != 2'd2)) begin
                            n_comp = 2'(r_comp + 2'd1);
                        end else begin
                            n_comp = 2'd0;
                            case (r_job)
                                J_DET:   n_job   = J_TAN;
                                J_NT:    n_state = S_BO;
                                default: n_state = S_NLOAD;
                            endcase
                        end
                    end
                endcase
            end
            S_NLOAD: begin
                w_cmd.op   = OP_NORM_LOAD;
                w_cmd.flip = r_job inside {J_TAN, J_BIN};
                n_state    = S_NSHIFT;
            end
            S_NSHIFT: begin
                if (i_status.shift_needed) begin
                    w_cmd.op = OP_NORM_SHIFT;
                end else begin
                    n_ph    = 2'd0;
                    n_state = S_SQ;
                end
            end
            S_SQ, S_DOT: begin
                n_ph = 2'(r_ph + 2'd1);
                if (r_ph != 2'd3) begin
                    if (r_state == S_SQ) begin
                        w_cmd.mul.a = opnd(G_MAG, {1'b0, r_ph});
                        w_cmd.mul.b = opnd(G_MAG, {1'b0, r_ph});
                    end else begin
                        w_cmd.mul.a = opnd(G_NRM, {1'b0, r_ph});
                        w_cmd.mul.b = opnd(G_FACE, {1'b0, r_ph});
                    end
                end
                case (r_ph)
                    2'd0:    w_cmd.acc_op = ACC_NONE;
                    2'd1:    w_cmd.acc_op = ACC_LOAD;
                    default: w_cmd.acc_op = ACC_ADD;
                endcase
                if (r_ph == 2'd3) begin
                    n_ph    = 2'd0;
                    n_state = (r_state == S_SQ) ? S_SQRT_INIT : S_FLIP;
                end
            end
            S_SQRT_INIT: begin
                w_cmd.op = OP_SQRT_INIT;
                n_cnt    = '0;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                w_cmd.op = OP_SQRT_STEP;
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    n_state = S_DIV_INIT;
                end else begin
                    n_cnt = CNT_W'(r_cnt + 1'b1);
                end
            end
            S_DIV_INIT: begin
                w_cmd.op = OP_DIV_INIT;
                n_cnt    = '0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                w_cmd.op = OP_DIV_STEP;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_NSTORE;
                end else begin
                    n_cnt = CNT_W'(r_cnt + 1'b1);
                end
            end
            S_NSTORE: begin
                w_cmd.op = OP_NORM_STORE;
                case (r_job)
                    J_TAN: begin
                        w_cmd.dest = VEC_TAN;
                        n_job      = J_BIN;
                        n_state    = S_CP;
                    end
                    J_BIN: begin
                        w_cmd.dest = VEC_BIN;
                        n_job      = J_TB;
                        n_state    = S_CP;
                    end
                    J_TB: begin
                        w_cmd.dest = VEC_NRM;
                        n_job      = J_NT;
                        n_state    = S_CP;
                    end
                    default: begin
                        w_cmd.dest = VEC_FACE;
                        n_ph       = 2'd0;
                        n_state    = S_DOT;
                    end
                endcase
            end
            S_BO: begin
                w_cmd.op = OP_BO;
                n_job    = J_FACE;
                n_state  = S_CP;
            end
            S_FLIP: begin
                w_cmd.op = OP_FLIP;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_cmd.op    = OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd       = w_cmd;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: hw/rtl/tts_datapath.sv
// ----------------------------------------------------------------------------
// Triangle tangent space: datapath
// Corner store, edges, shared multiply-accumulate, square root and dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_datapath import tts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  t_vtx        i_vtx,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output t_res        o_res
);

    logic signed [31:0]    w_in [5];
    logic signed [31:0]    r_c0 [5];
    logic signed [31:0]    r_c1 [5];
    logic signed [31:0]    r_e0 [5];
    logic signed [31:0]    r_e1 [5];
    logic signed [63:0]    r_prod, r_acc, r_det;
    logic signed [63:0]    r_v [3];
    logic [63:0]           r_m [3];
    logic                  r_neg [3];
    logic [63:0]           r_sx, r_sr, r_sbit;
    logic [45:0]           r_rem [3];
    logic [45:0]           r_dd;
    logic [DIV_STEPS-1:0]  r_q [3];
    logic signed [15:0]    r_tan [3];
    logic signed [15:0]    r_bin [3];
    logic signed [15:0]    r_nrm [3];
    logic signed [15:0]    r_face [3];
    logic signed [15:0]    r_bo [3];
    logic [15:0]           r_thr;
    t_res                  r_res;
    logic signed [31:0]    w_a, w_b;
    logic signed [63:0]    w_mul;
    logic [63:0]           w_strial;
    logic [31:0]           w_len;
    logic                  w_degen, w_flip;
    logic signed [15:0]    w_unit [3];

    function automatic logic signed [31:0] sat_edge(logic signed [31:0] a,
                                                    logic signed [31:0] b);
        logic signed [32:0] d;
        d = $signed({a[31], a}) - $signed({b[31], b});
        if (d > 33'sh07FFFFFFF)       sat_edge = 32'sh7FFFFFFF;
        else if (d < -33'sh07FFFFFFF) sat_edge = 32'sh80000001;
        else                          sat_edge = d[31:0];
    endfunction

    function automatic logic [63:0] mag64(logic signed [63:0] v);
        logic [63:0] u;
        u = v;
        mag64 = v[63] ? (~u + 64'd1) : u;
    endfunction

    function automatic logic signed [15:0] q28_to_q14(logic signed [63:0] v);
        logic [63:0] m;
        m = (mag64(v) + 64'd8192) >> 14;
        if (v[63]) q28_to_q14 = (m > 64'd32768) ? 16'sh8000 : 16'(~m[15:0] + 16'd1);
        else       q28_to_q14 = (m > 64'd32767) ? 16'sh7FFF : m[15:0];
    endfunction

    function automatic logic signed [31:0] pick(t_opnd o);
        case (o.grp)
            G_E0:    pick = r_e0[o.idx];
            G_E1:    pick = r_e1[o.idx];
            G_TAN:   pick = 32'(r_tan[o.idx[1:0]]);
            G_BIN:   pick = 32'(r_bin[o.idx[1:0]]);
            G_NRM:   pick = 32'(r_nrm[o.idx[1:0]]);
            G_FACE:  pick = 32'(r_face[o.idx[1:0]]);
            G_MAG:   pick = {2'b00, r_m[o.idx[1:0]][29:0]};
            default: pick = '0;
        endcase
    endfunction

    assign w_in[0] = i_vtx.pos_x;
    assign w_in[1] = i_vtx.pos_y;
    assign w_in[2] = i_vtx.pos_z;
    assign w_in[3] = i_vtx.tex_s;
    assign w_in[4] = i_vtx.tex_t;

    always_comb begin
        w_a = pick(i_cmd.mul.a);
        w_b = pick(i_cmd.mul.b);
    end

    assign w_mul    = w_a * w_b;
    assign w_strial = r_sr + r_sbit;
    assign w_len    = r_sr[31:0];
    assign w_degen  = mag64(r_det) <= {32'd0, r_thr, 16'd0};
    assign w_flip   = i_cmd.flip && (r_det > 64'sd0);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (w_len == 32'd0)  w_unit[i] = '0;
            else if (r_neg[i])   w_unit[i] = 16'(-{1'b0, r_q[i]});
            else                 w_unit[i] = {1'b0, r_q[i]};
        end
    end

    assign o_status.shift_needed = |(r_m[0][63:30] | r_m[1][63:30] | r_m[2][63:30]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul;
        case (i_cmd.acc_op)
            ACC_LOAD: r_acc <= r_prod;
            ACC_ADD:  r_acc <= r_acc + r_prod;
            ACC_SUB:  r_acc <= r_acc - r_prod;
            default:  r_acc <= r_acc;
        endcase
        if (i_cmd.st_det) begin
            r_det <= r_acc;
        end
        if (i_cmd.st_v) begin
            r_v[i_cmd.comp] <= (i_cmd.mask && w_degen) ? 64'sd0 : r_acc;
        end

        case (i_cmd.op)
            OP_CAP_FIRST: begin
                for (int i = 0; i < 5; i++) r_c0[i] <= w_in[i];
            end
            OP_CAP_SECOND: begin
                for (int i = 0; i < 5; i++) r_c1[i] <= w_in[i];
            end
            OP_EDGES: begin
                for (int i = 0; i < 5; i++) begin
                    r_e0[i] <= sat_edge(r_c1[i], r_c0[i]);
                    r_e1[i] <= sat_edge(w_in[i], r_c0[i]);
                end
            end
            OP_NORM_LOAD: begin
                for (int i = 0; i < 3; i++) begin
                    r_m[i]   <= mag64(r_v[i]);
                    r_neg[i] <= r_v[i][63] ^ w_flip;
                end
            end
            OP_NORM_SHIFT: begin
                for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
            end
            OP_SQRT_INIT: begin
                r_sx   <= r_acc;
                r_sr   <= '0;
                r_sbit <= 64'h4000_0000_0000_0000;
            end
            OP_SQRT_STEP: begin
                if (r_sx >= w_strial) begin
                    r_sx <= r_sx - w_strial;
                    r_sr <= (r_sr >> 1) + r_sbit;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sbit <= r_sbit >> 2;
            end
            OP_DIV_INIT: begin
                for (int i = 0; i < 3; i++) begin
                    r_rem[i] <= {2'b00, r_m[i][29:0], 14'd0} + 46'(w_len >> 1);
                    r_q[i]   <= '0;
                end
                r_dd <= {w_len, 14'd0};
            end
            OP_DIV_STEP: begin
                for (int i = 0; i < 3; i++) begin
                    if (r_rem[i] >= r_dd) begin
                        r_rem[i] <= r_rem[i] - r_dd;
                        r_q[i]   <= {r_q[i][DIV_STEPS-2:0], 1'b1};
                    end else begin
                        r_q[i]   <= {r_q[i][DIV_STEPS-2:0], 1'b0};
                    end
                end
                r_dd <= r_dd >> 1;
            end
            OP_NORM_STORE: begin
                for (int i = 0; i < 3; i++) begin
                    case (i_cmd.dest)
                        VEC_TAN: r_tan[i]  <= w_unit[i];
                        VEC_BIN: r_bin[i]  <= w_unit[i];
                        VEC_NRM: r_nrm[i]  <= w_unit[i];
                        default: r_face[i] <= w_unit[i];
                    endcase
                end
            end
            OP_BO: begin
                for (int i = 0; i < 3; i++) r_bo[i] <= q28_to_q14(r_v[i]);
            end
            OP_FLIP: begin
                if (r_acc[63]) begin
                    for (int i = 0; i < 3; i++) r_nrm[i] <= 16'(-r_nrm[i]);
                end
            end
            OP_OUT: begin
                r_res.tangent_x  <= r_tan[0];
                r_res.tangent_y  <= r_tan[1];
                r_res.tangent_z  <= r_tan[2];
                r_res.binormal_x <= r_bo[0];
                r_res.binormal_y <= r_bo[1];
                r_res.binormal_z <= r_bo[2];
                r_res.normal_x   <= r_nrm[0];
                r_res.normal_y   <= r_nrm[1];
                r_res.normal_z   <= r_nrm[2];
                r_res.degenerate <= w_degen;
            end
            default: ;
        endcase
    end

    assign o_res = r_res;

endmodule

`default_nettype wire
